### rtl/core/tmwf_pkg.sv
// ----------------------------------------------------------------------------
// tmwf_pkg
// Shared widths, defaults and the pipeline control bundle of the trimmed-mean
// window filter.
// ----------------------------------------------------------------------------
package tmwf_pkg;

    // Sample and result widths
    localparam int SAMPLE_W  = 16;
    localparam int MEAN_W    = 20;
    localparam int FRAC_BITS = 4;

    // Default window length (valid range 3 to 20)
    localparam int WINDOW_DEFAULT = 12;

    // Window entries folded together in the first reduction stage
    localparam int GROUP = 4;

    // Per-stage load enables driven by the top-level pipeline control
    typedef struct packed {
        logic load;     // item accepted, shift sample into window
        logic grp_en;   // group partial sums / min / max
        logic trim_en;  // trimmed sum, sign and magnitude
        logic mul_en;   // reciprocal product
        logic out_en;   // quotient correction and result register
    } ctrl_t;

endpackage

### rtl/core/tmwf_sample_if.sv
// ----------------------------------------------------------------------------
// tmwf_sample_if
// Input channel: one three-axis sample per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tmwf_sample_if;

    logic                                 valid;
    logic                                 ready;
    logic signed [tmwf_pkg::SAMPLE_W-1:0] acc_x;
    logic signed [tmwf_pkg::SAMPLE_W-1:0] acc_y;
    logic signed [tmwf_pkg::SAMPLE_W-1:0] acc_z;

    modport source (output valid, output acc_x, output acc_y, output acc_z, input ready);
    modport sink   (input valid, input acc_x, input acc_y, input acc_z, output ready);

endinterface

### rtl/core/tmwf_mean_if.sv
// ----------------------------------------------------------------------------
// tmwf_mean_if
// Output channel: one trimmed mean per axis per item, valid/ready handshake.
// ----------------------------------------------------------------------------
interface tmwf_mean_if;

    logic                               valid;
    logic                               ready;
    logic signed [tmwf_pkg::MEAN_W-1:0] mean_x;
    logic signed [tmwf_pkg::MEAN_W-1:0] mean_y;
    logic signed [tmwf_pkg::MEAN_W-1:0] mean_z;

    modport source (output valid, output mean_x, output mean_y, output mean_z, input ready);
    modport sink   (input valid, input mean_x, input mean_y, input mean_z, output ready);

endinterface

### rtl/core/tmwf_axis.sv
// ----------------------------------------------------------------------------
// tmwf_axis
// One axis datapath: sample window shift line, grouped sum/min/max
// reduction, trimmed sum, and division by WINDOW-2 through a reciprocal
// multiply with a single correction step.
// ----------------------------------------------------------------------------
module tmwf_axis #(
    parameter int WINDOW = tmwf_pkg::WINDOW_DEFAULT
) (
    input  logic                                 clk,
    input  tmwf_pkg::ctrl_t                      ctrl,
    input  logic signed [tmwf_pkg::SAMPLE_W-1:0] sample,
    output logic signed [tmwf_pkg::MEAN_W-1:0]   mean
);

    localparam int SW      = tmwf_pkg::SAMPLE_W;
    localparam int GRP     = tmwf_pkg::GROUP;
    localparam int NG      = (WINDOW + GRP - 1) / GRP;
    localparam int SUM_W   = SW + $clog2(WINDOW);
    localparam int MAG_W   = SUM_W + tmwf_pkg::FRAC_BITS;
    localparam int RECIP_W = MAG_W + 1;
    localparam int PROD_W  = MAG_W + RECIP_W;
    localparam int DIV     = WINDOW - 2;

    // floor(2^MAG_W / DIV); magnitude stays below 2^MAG_W so the estimate
    // is low by at most one
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << MAG_W) / DIV);
    localparam logic [MAG_W-1:0]   DIV_V = MAG_W'(DIV);

    // Window shift line, newest at index 0
    logic signed [SW-1:0] win_reg [WINDOW];

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            win_reg[0] <= sample;
            for (int i = 1; i < WINDOW; i++)
            begin
                win_reg[i] <= win_reg[i-1];
            end
        end
    end

    // Group partials: sum, min, max over up to GROUP entries each
    logic signed [SUM_W-1:0] gsum_next [NG];
    logic signed [SUM_W-1:0] gsum_reg  [NG];
    logic signed [SW-1:0]    gmin_next [NG];
    logic signed [SW-1:0]    gmin_reg  [NG];
    logic signed [SW-1:0]    gmax_next [NG];
    logic signed [SW-1:0]    gmax_reg  [NG];

    always_comb
    begin
        for (int g = 0; g < NG; g++)
        begin
            gsum_next[g] = SUM_W'(win_reg[g*GRP]);
            gmin_next[g] = win_reg[g*GRP];
            gmax_next[g] = win_reg[g*GRP];
            for (int k = 1; k < GRP; k++)
            begin
                if (g*GRP + k < WINDOW)
                begin
                    gsum_next[g] = gsum_next[g] + SUM_W'(win_reg[g*GRP + k]);
                    if (win_reg[g*GRP + k] < gmin_next[g])
                    begin
                        gmin_next[g] = win_reg[g*GRP + k];
                    end
                    if (win_reg[g*GRP + k] > gmax_next[g])
                    begin
                        gmax_next[g] = win_reg[g*GRP + k];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.grp_en)
        begin
            gsum_reg <= gsum_next;
            gmin_reg <= gmin_next;
            gmax_reg <= gmax_next;
        end
    end

    // Combine groups, drop one min and one max, scale by 16 as magnitude
    logic signed [SUM_W-1:0] tsum;
    logic signed [SW-1:0]    tmin;
    logic signed [SW-1:0]    tmax;
    logic signed [SUM_W-1:0] trim;
    logic [SUM_W-1:0]        trim_abs;
    logic [MAG_W-1:0]        mag_next;
    logic [MAG_W-1:0]        mag_reg;
    logic                    neg_reg;

    always_comb
    begin
        tsum = gsum_reg[0];
        tmin = gmin_reg[0];
        tmax = gmax_reg[0];
        for (int g = 1; g < NG; g++)
        begin
            tsum = tsum + gsum_reg[g];
            if (gmin_reg[g] < tmin)
            begin
                tmin = gmin_reg[g];
            end
            if (gmax_reg[g] > tmax)
            begin
                tmax = gmax_reg[g];
            end
        end
        trim     = tsum - SUM_W'(tmin) - SUM_W'(tmax);
        trim_abs = trim[SUM_W-1] ? unsigned'(-trim) : unsigned'(trim);
        mag_next = {trim_abs, {tmwf_pkg::FRAC_BITS{1'b0}}};
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.trim_en)
        begin
            mag_reg <= mag_next;
            neg_reg <= trim[SUM_W-1];
        end
    end

    // Reciprocal product
    logic [PROD_W-1:0] prod_reg;
    logic [MAG_W-1:0]  mag2_reg;
    logic              neg2_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(RECIP);
            mag2_reg <= mag_reg;
            neg2_reg <= neg_reg;
        end
    end

    // Quotient estimate, one correction step, sign restore
    logic [MAG_W-1:0] q_est;
    logic [MAG_W-1:0] rem;
    logic [MAG_W-1:0] q_fix;
    logic [MAG_W-1:0] res;
    logic signed [tmwf_pkg::MEAN_W-1:0] mean_reg;

    always_comb
    begin
        q_est = prod_reg[MAG_W +: MAG_W];
        rem   = mag2_reg - MAG_W'(q_est * DIV_V);
        q_fix = (rem >= DIV_V) ? q_est + MAG_W'(1) : q_est;
        res   = neg2_reg ? (~q_fix + MAG_W'(1)) : q_fix;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.out_en)
        begin
            mean_reg <= signed'(res[tmwf_pkg::MEAN_W-1:0]);
        end
    end

    assign mean = mean_reg;

endmodule

### rtl/core/trimmed_mean_window_filter_top.sv
// ----------------------------------------------------------------------------
// trimmed_mean_window_filter_top
// Three-axis trimmed-mean moving-average filter with valid/ready channels.
// ----------------------------------------------------------------------------
// Usage:
//   samples : sink channel, one signed 16-bit sample per axis per item.
//   means   : source channel, per axis (window sum - min - max) * 16 /
//             (WINDOW-2), truncated toward zero, signed with 4 fraction bits.
//   The first WINDOW-1 items after reset only fill the window and give no
//   result; from the WINDOW-th item on, every item gives one result.
//   A result is built by window shift, group reduction, trimmed sum,
//   reciprocal multiply and correction into the output register, in that
//   order. Throughput: one item per cycle while means.ready is high,
//   set by the five-stage register pipeline.
//   Reset clears the fill count and all stage valid bits; window contents
//   are not cleared and are only used once fully written.
//   When the receiver stalls, stages fill up behind the output register
//   (bubbles are squeezed out) and samples.ready drops once the window
//   stage holds an item whose result cannot yet move on.
// ----------------------------------------------------------------------------
module trimmed_mean_window_filter_top #(
    parameter int WINDOW = tmwf_pkg::WINDOW_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    tmwf_sample_if.sink  samples,
    tmwf_mean_if.source  means
);

    localparam int CNT_W = $clog2(WINDOW);

    tmwf_pkg::ctrl_t ctrl;

    logic             fill_full_reg;
    logic [CNT_W-1:0] fill_cnt_reg;
    logic             gives_result;
    logic             win_v_reg;
    logic             grp_v_reg;
    logic             trim_v_reg;
    logic             mul_v_reg;
    logic             out_v_reg;
    logic             win_en;

    // Stage enables: a stage loads when it is empty or its successor loads
    always_comb
    begin
        ctrl.out_en  = !out_v_reg  || means.ready;
        ctrl.mul_en  = !mul_v_reg  || ctrl.out_en;
        ctrl.trim_en = !trim_v_reg || ctrl.mul_en;
        ctrl.grp_en  = !grp_v_reg  || ctrl.trim_en;
        win_en       = !win_v_reg  || ctrl.grp_en;
        ctrl.load    = samples.valid && win_en;
    end

    assign samples.ready = win_en;
    assign gives_result  = fill_full_reg || (fill_cnt_reg == CNT_W'(WINDOW - 1));

    // Fill count and stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_full_reg <= 1'b0;
            fill_cnt_reg  <= '0;
            win_v_reg     <= 1'b0;
            grp_v_reg     <= 1'b0;
            trim_v_reg    <= 1'b0;
            mul_v_reg     <= 1'b0;
            out_v_reg     <= 1'b0;
        end
        else
        begin
            if (ctrl.load && !fill_full_reg)
            begin
                if (fill_cnt_reg == CNT_W'(WINDOW - 1))
                begin
                    fill_full_reg <= 1'b1;
                end
                else
                begin
                    fill_cnt_reg <= fill_cnt_reg + CNT_W'(1);
                end
            end
            if (win_en)
            begin
                win_v_reg <= ctrl.load && gives_result;
            end
            if (ctrl.grp_en)
            begin
                grp_v_reg <= win_v_reg;
            end
            if (ctrl.trim_en)
            begin
                trim_v_reg <= grp_v_reg;
            end
            if (ctrl.mul_en)
            begin
                mul_v_reg <= trim_v_reg;
            end
            if (ctrl.out_en)
            begin
                out_v_reg <= mul_v_reg;
            end
        end
    end

    assign means.valid = out_v_reg;

    // Per-axis datapaths
    tmwf_axis #(.WINDOW(WINDOW)) u_axis_x (
        .clk    (clk),
        .ctrl   (ctrl),
        .sample (samples.acc_x),
        .mean   (means.mean_x)
    );

    tmwf_axis #(.WINDOW(WINDOW)) u_axis_y (
        .clk    (clk),
        .ctrl   (ctrl),
        .sample (samples.acc_y),
        .mean   (means.mean_y)
    );

    tmwf_axis #(.WINDOW(WINDOW)) u_axis_z (
        .clk    (clk),
        .ctrl   (ctrl),
        .sample (samples.acc_z),
        .mean   (means.mean_z)
    );

endmodule
